// ===== hw/rtl/record_sort_by_key_core_assert.svh =====
// assertion macros for the record sort core
`ifndef RECORD_SORT_BY_KEY_CORE_ASSERT_SVH
`define RECORD_SORT_BY_KEY_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define RSK_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("record sort core: same-cycle check failed");
`define RSK_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("record sort core: next-cycle check failed");
`else
`define RSK_ASSERT_IMPL(lbl, ante, cons)
`define RSK_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hw/rtl/rsk_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rsk_pkg;

  localparam int RSK_CAPACITY = 16;
  localparam int ID_W  = 31;
  localparam int SAL_W = 31;
  localparam int HND_W = 16;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [SAL_W-1:0] salary;
    logic [HND_W-1:0] handle;
  } rec_t;

  // per-cycle commands broadcast to every cell
  typedef struct packed {
    logic ins;  // insert the broadcast record
    logic pop;  // shift everything one place toward the output
  } cell_ctl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/rsk_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rsk_cell
  import rsk_pkg::*;
(
  input  wire logic      clk,
  input  wire cell_ctl_t ctl,
  input  wire rec_t      new_rec,
  input  wire logic      occ,       // this slot holds a stored record
  input  wire logic      left_gt,   // left neighbor moves right on insert
  input  wire rec_t      left_rec,
  input  wire rec_t      right_rec,
  output logic           gt,
  output rec_t           rec
);

  rec_t rec_r;
  rec_t rec_nxt;

  // strictly greater keeps equal ids in arrival order
  assign gt  = occ && (rec_r.id > new_rec.id);
  assign rec = rec_r;

  always_comb begin
    rec_nxt = rec_r;
    if (ctl.pop) begin
      rec_nxt = right_rec;
    end else if (ctl.ins) begin
      if (left_gt) begin
        rec_nxt = left_rec;
      end else if (!occ || gt) begin
        rec_nxt = new_rec;
      end
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/record_sort_by_key_core.sv =====
// record_sort_by_key_core: stable ascending sort of records by id
//
// input channel: one record word per accepted cycle (id, salary, name handle)
// with in_last_record marking the end of a list. records load at one per
// cycle while in_stall is low; each word is placed in the cell chain in
// the cycle it is accepted. a list's records come out on the result channel
// in ascending id order, equal ids in arrival order, out_last_out on the
// final word. words beyond CAPACITY are dropped and out_overflow is set on
// every result word of that list.
// the first result word is valid the cycle after the last record is
// accepted. while draining, in_stall is high. the pace is set by the single
// output tap at cell zero, which shifts the chain one place per word.
// out_stall holds the chain frozen and the presented word stable.
// reset (rst_n low, synchronous) empties the store and clears overflow.
`timescale 1ns / 1ps
`default_nettype none
`include "record_sort_by_key_core_assert.svh"
module record_sort_by_key_core
  import rsk_pkg::*;
#(
  parameter int CAPACITY = RSK_CAPACITY
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [ID_W-1:0]  in_employee_id,
  input  wire logic [SAL_W-1:0] in_base_salary,
  input  wire logic [HND_W-1:0] in_name_handle,
  input  wire logic             in_last_record,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [ID_W-1:0]       out_sorted_id,
  output logic [SAL_W-1:0]      out_sorted_salary,
  output logic [HND_W-1:0]      out_sorted_name_handle,
  output logic                  out_last_out,
  output logic                  out_overflow
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

  // control registers
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             drain_r, drain_nxt;
  logic             ovf_r, ovf_nxt;

  logic      in_acc;
  logic      full;
  logic      pop;
  cell_ctl_t ctl;
  rec_t      new_rec;

  // chain wiring
  rec_t              cell_rec [CAPACITY];
  logic [CAPACITY-1:0] cell_gt;
  logic [CAPACITY-1:0] cell_occ;

  assign in_acc  = in_valid && !in_stall;
  assign full    = (count_r == CNT_FULL);
  assign pop     = drain_r && !out_stall;
  assign ctl.ins = in_acc && !full;
  assign ctl.pop = pop;

  assign new_rec.id     = in_employee_id;
  assign new_rec.salary = in_base_salary;
  assign new_rec.handle = in_name_handle;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      rec_t left_rec;
      rec_t right_rec;
      logic left_gt;

      // slot is occupied when below the fill count
      assign cell_occ[gi] = (CNT_W'(gi) < count_r);

      if (gi == 0) begin : g_head
        assign left_rec = new_rec;
        assign left_gt  = 1'b0;
      end else begin : g_body
        assign left_rec = cell_rec[gi-1];
        assign left_gt  = cell_gt[gi-1];
      end

      if (gi == CAPACITY - 1) begin : g_tail
        assign right_rec = cell_rec[gi];   // tail slot falls outside the count
      end else begin : g_mid
        assign right_rec = cell_rec[gi+1];
      end

      rsk_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .new_rec   (new_rec),
        .occ       (cell_occ[gi]),
        .left_gt   (left_gt),
        .left_rec  (left_rec),
        .right_rec (right_rec),
        .gt        (cell_gt[gi]),
        .rec       (cell_rec[gi])
      );
    end
  endgenerate

  // fill count, drain flag and overflow flag
  always_comb begin
    count_nxt = count_r;
    drain_nxt = drain_r;
    ovf_nxt   = ovf_r;
    if (pop) begin
      count_nxt = count_r - CNT_ONE;
      if (count_r == CNT_ONE) begin
        drain_nxt = 1'b0;
        ovf_nxt   = 1'b0;
      end
    end else if (in_acc) begin
      if (full) begin
        ovf_nxt = 1'b1;   // store full, word dropped
      end else begin
        count_nxt = count_r + CNT_ONE;
      end
      if (in_last_record) begin
        drain_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      drain_r <= 1'b0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      drain_r <= drain_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // no loading while a list drains
  assign in_stall = drain_r;

  // results come straight from the head cell
  assign out_valid              = drain_r;
  assign out_sorted_id          = cell_rec[0].id;
  assign out_sorted_salary      = cell_rec[0].salary;
  assign out_sorted_name_handle = cell_rec[0].handle;
  assign out_last_out           = (count_r == CNT_ONE);
  assign out_overflow           = ovf_r;

  // checks
  `RSK_ASSERT_IMPL(a_drain_nonempty, drain_r, count_r != '0)
  `RSK_ASSERT_IMPL(a_count_bound, 1'b1, count_r <= CNT_FULL)
  `RSK_ASSERT_NEXT(a_drop_flags, in_acc && full, ovf_r)
  `RSK_ASSERT_NEXT(a_list_done, pop && (count_r == CNT_ONE), !drain_r && (count_r == '0))

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import rsk_pkg::*;

  localparam int CAP         = RSK_CAPACITY;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;
  localparam int RAND_ITEMS  = 80;
  localparam int DRAIN_WAIT  = 2 * CAP + 8;

  localparam logic [ID_W-1:0]  ID_MAX  = '1;
  localparam logic [SAL_W-1:0] SAL_MAX = '1;
  localparam logic [HND_W-1:0] HND_MAX = '1;

  // one word on the result channel
  typedef struct packed {
    rec_t rec;
    logic last;
    logic ovf;
  } sorted_word_t;

  // one word on the input channel; typed rows carry their own expected word
  typedef struct {
    rec_t         rec;
    logic         last;
    logic         typed;
    sorted_word_t want;
  } record_entry_t;

  // idling regimes, stepped through as input words are taken
  typedef enum logic [1:0] {
    MODE_FREE,
    MODE_SRC_IDLE,
    MODE_SINK_STALL,
    MODE_BOTH_IDLE
  } idle_mode_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [ID_W-1:0]   in_employee_id = '0;
  logic [SAL_W-1:0]  in_base_salary = '0;
  logic [HND_W-1:0]  in_name_handle = '0;
  logic              in_last_record = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [ID_W-1:0]   out_sorted_id;
  logic [SAL_W-1:0]  out_sorted_salary;
  logic [HND_W-1:0]  out_sorted_name_handle;
  logic              out_last_out;
  logic              out_overflow;

  record_sort_by_key_core dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_employee_id         (in_employee_id),
    .in_base_salary         (in_base_salary),
    .in_name_handle         (in_name_handle),
    .in_last_record         (in_last_record),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_sorted_id          (out_sorted_id),
    .out_sorted_salary      (out_sorted_salary),
    .out_sorted_name_handle (out_sorted_name_handle),
    .out_last_out           (out_last_out),
    .out_overflow           (out_overflow)
  );

  // 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  int cycle_count = 0;
  always @(posedge clk) cycle_count <= cycle_count + 1;

  // stimulus and expectations
  record_entry_t stim_q[$];
  sorted_word_t  awaiting_words[$];
  int            errors = 0;
  int            words_checked = 0;
  int            n_taken = 0;
  int            next_idx = 0;
  idle_mode_t    idle_mode = MODE_FREE;
  logic          sink_hold = 1'b0;
  logic          timed_out = 1'b0;

  // predictor state: records of the open list, kept in ascending id order
  rec_t held_recs [CAP];
  int   held_cnt = 0;
  logic held_drop = 1'b0;

  function automatic record_entry_t plain_row(input logic [ID_W-1:0] id,
                                              input logic [SAL_W-1:0] sal,
                                              input logic [HND_W-1:0] hnd,
                                              input logic last);
    record_entry_t e;
    e.rec   = '{id: id, salary: sal, handle: hnd};
    e.last  = last;
    e.typed = 1'b0;
    e.want  = '0;
    return e;
  endfunction

  // a single-record list comes straight back, marked last, no overflow
  function automatic record_entry_t solo_row(input logic [ID_W-1:0] id,
                                             input logic [SAL_W-1:0] sal,
                                             input logic [HND_W-1:0] hnd);
    record_entry_t e;
    e       = plain_row(id, sal, hnd, 1'b1);
    e.typed = 1'b1;
    e.want  = '{rec: '{id: id, salary: sal, handle: hnd}, last: 1'b1, ovf: 1'b0};
    return e;
  endfunction

  // append a stimulus row at the tail
  task automatic add_row(input record_entry_t e);
    stim_q.insert(stim_q.size(), e);
  endtask

  // append an expected word at the tail
  task automatic add_word(input sorted_word_t w);
    awaiting_words.insert(awaiting_words.size(), w);
  endtask

  // insertion after every equal id keeps arrival order among ties
  task automatic take_record(input record_entry_t e);
    int pos;
    if (held_cnt >= CAP) begin
      held_drop = 1'b1;
    end else begin
      pos = held_cnt;
      while (pos > 0 && held_recs[pos-1].id > e.rec.id) begin
        held_recs[pos] = held_recs[pos-1];
        pos--;
      end
      held_recs[pos] = e.rec;
      held_cnt++;
    end
    if (e.last) begin
      if (e.typed) begin
        add_word(e.want);
      end else begin
        for (int k = 0; k < held_cnt; k++)
          add_word(sorted_word_t'{rec: held_recs[k], last: (k == held_cnt - 1),
                                  ovf: held_drop});
      end
      held_cnt  = 0;
      held_drop = 1'b0;
    end
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
      errors++;
    end
  endtask

  // sender: once a word is taken or none is up, offers the next or idles by mode
  record_entry_t cur_entry;
  int            src_pct;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        take_record(cur_entry);
        n_taken++;
      end
      if (!in_valid || !in_stall) begin
        src_pct = (idle_mode == MODE_SRC_IDLE) ? 62 :
                  (idle_mode == MODE_BOTH_IDLE) ? 11 : 0;
        // while the sink holds off, keep offering so the input backs up
        if (next_idx < stim_q.size() &&
            (sink_hold || $urandom_range(99) >= src_pct)) begin
          cur_entry = stim_q[next_idx];
          next_idx++;
          in_valid       <= 1'b1;
          in_employee_id <= cur_entry.rec.id;
          in_base_salary <= cur_entry.rec.salary;
          in_name_handle <= cur_entry.rec.handle;
          in_last_record <= cur_entry.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
      idle_mode <= idle_mode_t'((n_taken / 16) % 4);
    end
  end

  // receiver: random stall by mode, plus the long hold-off
  int sink_pct;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      sink_pct = (idle_mode == MODE_SINK_STALL) ? 62 :
                 (idle_mode == MODE_BOTH_IDLE) ? 11 : 0;
      out_stall <= sink_hold || ($urandom_range(99) < sink_pct);
    end
  end

  // long hold-off once a drain is under way, counted in its own cycles
  int hold_cnt;
  initial begin
    wait (words_checked >= 30);
    do @(posedge clk); while (!out_valid);
    sink_hold <= 1'b1;
    for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) @(posedge clk);
    sink_hold <= 1'b0;
  end

  // result checker: every taken word against the oldest expectation
  sorted_word_t want_word;
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (awaiting_words.size() == 0) begin
        $display("%0t: unexpected result word, expected none actual id %h",
                 $time, out_sorted_id);
        errors++;
      end else begin
        want_word = awaiting_words.pop_front();
        check_field("sorted_id", 32'(want_word.rec.id), 32'(out_sorted_id));
        check_field("sorted_salary", 32'(want_word.rec.salary), 32'(out_sorted_salary));
        check_field("sorted_name_handle", 32'(want_word.rec.handle),
                    32'(out_sorted_name_handle));
        check_field("last_out", 32'(want_word.last), 32'(out_last_out));
        check_field("overflow", 32'(want_word.ovf), 32'(out_overflow));
      end
      words_checked++;
    end
  end

  int list_len;
  int dir_count;
  logic [ID_W-1:0] rid;
  initial begin
    // directed table
    // single record right after reset, all zero
    add_row(solo_row('0, '0, '0));
    // single record, every field at its maximum
    add_row(solo_row(ID_MAX, SAL_MAX, HND_MAX));
    // out of order list with a tie on id 5: arrival order must hold
    add_row(plain_row(31'd5, 31'h1111, 16'h000a, 1'b0));
    add_row(plain_row(31'd3, 31'h2222, 16'h000b, 1'b0));
    add_row(plain_row(31'd5, 31'h3333, 16'h000c, 1'b0));
    add_row(plain_row(31'd1, 31'h4444, 16'h000d, 1'b1));
    // full store, then the closing record is dropped: overflow on all words
    for (int k = 0; k <= CAP; k++)
      add_row(plain_row((k == 0) ? ID_MAX : ID_W'((CAP - k) >> 1),
                        (k % 2) ? SAL_MAX : '0, HND_W'(k), k == CAP));
    dir_count = stim_q.size();

    // random lists, mostly within capacity, some past it
    while (stim_q.size() < dir_count + RAND_ITEMS) begin
      list_len = ($urandom_range(5) == 0) ? $urandom_range(CAP + 1, CAP + 4)
                                          : $urandom_range(1, CAP);
      for (int k = 0; k < list_len; k++) begin
        case ($urandom_range(3))
          0, 1:    rid = ID_W'($urandom_range(7));
          2:       rid = ID_W'($urandom);
          default: rid = $urandom_range(1) ? ID_MAX : '0;
        endcase
        add_row(plain_row(rid, SAL_W'($urandom), HND_W'($urandom),
                          k == list_len - 1));
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    fork
      begin
        wait (n_taken == stim_q.size() && awaiting_words.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
      end
      begin
        wait (cycle_count >= CYCLE_LIMIT);
        timed_out = 1'b1;
      end
    join_any
    disable fork;

    if (timed_out) begin
      $display("%0t: timeout after %0d cycles, %0d words still expected",
               $time, cycle_count, awaiting_words.size());
      errors++;
    end
    if (awaiting_words.size() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, awaiting_words.size());
      errors++;
    end
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/rsk_pkg.sv
hw/rtl/rsk_cell.sv
hw/rtl/record_sort_by_key_core.sv
verif/tb_top.sv
